// ----- design/cdes_pkg.sv -----
// ============================================================================
// cdes_pkg
// shared widths, constants and control types for the date to epoch pipeline
// ============================================================================
package cdes_pkg;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 8;
    localparam int DAY_W      = 10;
    localparam int HMS_W      = 8;
    localparam int FRAC_W     = 16;
    localparam int SEC_W      = 37;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 56;

    localparam int YEAR_S_W   = 16;
    localparam int TOD_W      = 20;
    localparam int DAYS_W     = 24;
    localparam int PROD_W     = 42;
    localparam int PIPE_DEPTH = 5;

    localparam logic signed [DAYS_W-1:0] EPOCH_DAYS =
        DAYS_W'(1969 * 365 + 1969 / 4 - 1969 / 100 + 1969 / 400);

    // floor carry of the zero-based month: bias by 11 years of months
    localparam logic [8:0]  MONTH_BIAS    = 9'd132;
    localparam logic [8:0]  RECIP12       = 9'd342;
    localparam int          RECIP12_SHIFT = 12;
    localparam logic [12:0] RECIP25       = 13'd5243;
    localparam int          RECIP25_SHIFT = 17;

    localparam logic signed [PROD_W-1:0] SEC_MAX =
        PROD_W'((longint'(1) <<< (SEC_W - 1)) - longint'(1));
    localparam logic signed [PROD_W-1:0] SEC_MIN = -SEC_MAX - PROD_W'(1);

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_date_en;

    typedef struct packed {
        logic s4;
        logic s5;
    } t_time_en;

    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- design/cdes_date_pipe.sv -----
// ============================================================================
// cdes_date_pipe
// three stages: month carry and time of day, year quotients, day count
// ============================================================================
module cdes_date_pipe (
    input  logic                                 i_clk,
    input  cdes_pkg::t_date_en                   i_en,
    input  logic        [cdes_pkg::YEAR_W-1:0]   i_year,
    input  logic        [cdes_pkg::MONTH_W-1:0]  i_month,
    input  logic        [cdes_pkg::DAY_W-1:0]    i_day,
    input  logic        [cdes_pkg::HMS_W-1:0]    i_hour,
    input  logic        [cdes_pkg::HMS_W-1:0]    i_minute,
    input  logic        [cdes_pkg::HMS_W-1:0]    i_whole_second,
    input  logic        [cdes_pkg::FRAC_W-1:0]   i_second_fraction,
    output logic signed [cdes_pkg::DAYS_W-1:0]  o_days,
    output logic signed [cdes_pkg::TOD_W-1:0]   o_tod,
    output logic        [cdes_pkg::FRAC_W-1:0]   o_frac
);
    import cdes_pkg::*;

    // stage 1
    logic signed [8:0]          w_mm;
    logic [8:0]                 w_mx;
    logic [17:0]                w_mprod;
    logic [4:0]                 w_mq;
    logic [8:0]                 w_mrem;
    logic signed [YEAR_S_W-1:0] w_yc;
    logic signed [TOD_W-1:0]    w_tod;

    logic signed [YEAR_S_W-1:0] r1_yc;
    logic [3:0]                 r1_mr;
    logic [DAY_W-1:0]           r1_day;
    logic signed [TOD_W-1:0]    r1_tod;
    logic [FRAC_W-1:0]          r1_frac;

    // stage 2
    logic signed [YEAR_S_W-1:0] w_y;
    logic [YEAR_S_W-1:0]        w_yabs;
    logic [YEAR_S_W-1:0]        w_babs;
    logic [25:0]                w_yp100;
    logic [25:0]                w_yp400;
    logic [25:0]                w_bp100;
    logic [25:0]                w_bp400;
    logic signed [DAYS_W-1:0]   w_y365;

    logic signed [DAYS_W-1:0]   r2_y365;
    logic                       r2_yneg;
    logic [12:0]                r2_q4;
    logic [8:0]                 r2_q100;
    logic [8:0]                 r2_q400;
    logic [3:0]                 r2_blo;
    logic [12:0]                r2_bc4;
    logic [10:0]                r2_bc16;
    logic [8:0]                 r2_bq100;
    logic [8:0]                 r2_bq400;
    logic [3:0]                 r2_mr;
    logic [DAY_W-1:0]           r2_day;
    logic signed [TOD_W-1:0]    r2_tod;
    logic [FRAC_W-1:0]          r2_frac;

    // stage 3
    logic                       w_div100;
    logic                       w_div400;
    logic                       w_leap_add;
    logic signed [DAYS_W-1:0]   w_s4;
    logic signed [DAYS_W-1:0]   w_s100;
    logic signed [DAYS_W-1:0]   w_s400;
    logic [8:0]                 w_dbm;
    logic signed [DAYS_W-1:0]   w_days;

    always_comb begin
        w_mm    = $signed({i_month[MONTH_W-1], i_month}) - 9'sd1;
        w_mx    = $unsigned(w_mm) + MONTH_BIAS;
        w_mprod = w_mx * RECIP12;
        w_mq    = w_mprod[RECIP12_SHIFT+4:RECIP12_SHIFT];
        w_mrem  = w_mx - {4'b0, w_mq} * 9'd12;
        w_yc    = $signed({2'b00, i_year}) + $signed({11'b0, w_mq}) - 16'sd11;
        w_tod   = $signed({{(TOD_W-HMS_W){i_hour[HMS_W-1]}}, i_hour}) * 20'sd3600
                + $signed({{(TOD_W-HMS_W){i_minute[HMS_W-1]}}, i_minute}) * 20'sd60
                + $signed({{(TOD_W-HMS_W){i_whole_second[HMS_W-1]}}, i_whole_second});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_yc   <= w_yc;
            r1_mr   <= w_mrem[3:0];
            r1_day  <= i_day;
            r1_tod  <= w_tod;
            r1_frac <= i_second_fraction;
        end
    end

    always_comb begin
        w_y     = r1_yc - 16'sd1;
        w_yabs  = w_y[YEAR_S_W-1] ? (~w_y + 16'd1) : w_y;
        w_babs  = r1_yc[YEAR_S_W-1] ? (~r1_yc + 16'd1) : r1_yc;
        w_yp100 = w_yabs[14:2] * RECIP25;
        w_yp400 = {2'b00, w_yabs[14:4]} * RECIP25;
        w_bp100 = w_babs[14:2] * RECIP25;
        w_bp400 = {2'b00, w_babs[14:4]} * RECIP25;
        w_y365  = $signed({{(DAYS_W-YEAR_S_W){w_y[YEAR_S_W-1]}}, w_y}) * 24'sd365;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_y365  <= w_y365;
            r2_yneg  <= w_y[YEAR_S_W-1];
            r2_q4    <= w_yabs[14:2];
            r2_q100  <= w_yp100[25:RECIP25_SHIFT];
            r2_q400  <= w_yp400[25:RECIP25_SHIFT];
            r2_blo   <= w_babs[3:0];
            r2_bc4   <= w_babs[14:2];
            r2_bc16  <= w_babs[14:4];
            r2_bq100 <= w_bp100[25:RECIP25_SHIFT];
            r2_bq400 <= w_bp400[25:RECIP25_SHIFT];
            r2_mr    <= r1_mr;
            r2_day   <= r1_day;
            r2_tod   <= r1_tod;
            r2_frac  <= r1_frac;
        end
    end

    always_comb begin
        w_div100   = (r2_bc4 == {4'b0, r2_bq100} * 13'd25);
        w_div400   = (r2_blo == 4'd0) && ({2'b00, r2_bc16} == {4'b0, r2_bq400} * 13'd25);
        w_leap_add = (r2_mr > 4'd1) && (r2_blo[1:0] == 2'd0) && (!w_div100 || w_div400);
        w_s4       = r2_yneg ? -$signed({11'b0, r2_q4}) : $signed({11'b0, r2_q4});
        w_s100     = r2_yneg ? -$signed({15'b0, r2_q100}) : $signed({15'b0, r2_q100});
        w_s400     = r2_yneg ? -$signed({15'b0, r2_q400}) : $signed({15'b0, r2_q400});
        w_dbm      = days_before_month(r2_mr);
        w_days     = r2_y365 + w_s4 - w_s100 + w_s400
                   + $signed({15'b0, w_dbm}) + $signed({23'b0, w_leap_add})
                   + $signed({{(DAYS_W-DAY_W){r2_day[DAY_W-1]}}, r2_day})
                   - 24'sd1 - EPOCH_DAYS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            o_days <= w_days;
            o_tod  <= r2_tod;
            o_frac <= r2_frac;
        end
    end

endmodule

// ----- design/cdes_time_pipe.sv -----
// ============================================================================
// cdes_time_pipe
// two stages: days to seconds product, time of day add and range clamp
// ============================================================================
module cdes_time_pipe (
    input  logic                                 i_clk,
    input  cdes_pkg::t_time_en                   i_en,
    input  logic signed [cdes_pkg::DAYS_W-1:0]  i_days,
    input  logic signed [cdes_pkg::TOD_W-1:0]   i_tod,
    input  logic        [cdes_pkg::FRAC_W-1:0]   i_frac,
    output logic        [cdes_pkg::SEC_W-1:0]    o_epoch_seconds,
    output logic        [cdes_pkg::FRAC_W-1:0]   o_epoch_fraction
);
    import cdes_pkg::*;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r4_prod;
    logic signed [TOD_W-1:0]  r4_tod;
    logic [FRAC_W-1:0]        r4_frac;

    logic signed [PROD_W-1:0] w_sec;
    logic [SEC_W-1:0]         w_out_sec;
    logic [FRAC_W-1:0]        w_out_frac;

    always_comb begin
        w_prod = $signed({{(PROD_W-DAYS_W){i_days[DAYS_W-1]}}, i_days}) * 42'sd86400;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_prod <= w_prod;
            r4_tod  <= i_tod;
            r4_frac <= i_frac;
        end
    end

    always_comb begin
        w_sec = r4_prod + $signed({{(PROD_W-TOD_W){r4_tod[TOD_W-1]}}, r4_tod});
        if (w_sec > SEC_MAX) begin
            w_out_sec  = SEC_MAX[SEC_W-1:0];
            w_out_frac = '1;
        end else if (w_sec < SEC_MIN) begin
            w_out_sec  = SEC_MIN[SEC_W-1:0];
            w_out_frac = '0;
        end else begin
            w_out_sec  = w_sec[SEC_W-1:0];
            w_out_frac = r4_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            o_epoch_seconds  <= w_out_sec;
            o_epoch_fraction <= w_out_frac;
        end
    end

endmodule

// ----- design/civil_date_to_epoch_seconds.sv -----
// beats pass stages s1 to s5 in turn; throughput: one beat per cycle unless
// m_axis stalls; stages fill bubbles independently, so the
// input stays ready under an output stall until all five stages hold a beat
// reset: synchronous active low, clears the stage valid bits only
// ============================================================================
// civil_date_to_epoch_seconds
// proleptic gregorian date and time to 37.16 fixed point seconds since 1970
// ============================================================================
module civil_date_to_epoch_seconds (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // year, month, day, hour, minute, whole_second, second_fraction
    input  logic [cdes_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // epoch_seconds, epoch_fraction, zero pad
    output logic [cdes_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import cdes_pkg::*;

    logic [PIPE_DEPTH-1:0]    r_vld;
    logic [PIPE_DEPTH-1:0]    n_vld;
    logic [PIPE_DEPTH-1:0]    w_adv;
    t_date_en                 w_date_en;
    t_time_en                 w_time_en;

    logic signed [DAYS_W-1:0] w_days;
    logic signed [TOD_W-1:0]  w_tod;
    logic [FRAC_W-1:0]        w_frac;
    logic [SEC_W-1:0]         w_epoch_seconds;
    logic [FRAC_W-1:0]        w_epoch_fraction;

    always_comb begin
        w_adv[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = s_axis_tvalid;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
        w_date_en = '{s1: w_adv[0], s2: w_adv[1], s3: w_adv[2]};
        w_time_en = '{s4: w_adv[3], s5: w_adv[4]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    cdes_date_pipe u_date (
        .i_clk             (i_clk),
        .i_en              (w_date_en),
        .i_year            (s_axis_tdata[13:0]),
        .i_month           (s_axis_tdata[21:14]),
        .i_day             (s_axis_tdata[31:22]),
        .i_hour            (s_axis_tdata[39:32]),
        .i_minute          (s_axis_tdata[47:40]),
        .i_whole_second    (s_axis_tdata[55:48]),
        .i_second_fraction (s_axis_tdata[71:56]),
        .o_days            (w_days),
        .o_tod             (w_tod),
        .o_frac            (w_frac)
    );

    cdes_time_pipe u_time (
        .i_clk            (i_clk),
        .i_en             (w_time_en),
        .i_days           (w_days),
        .i_tod            (w_tod),
        .i_frac           (w_frac),
        .o_epoch_seconds  (w_epoch_seconds),
        .o_epoch_fraction (w_epoch_fraction)
    );

    assign s_axis_tready = w_adv[0];
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign m_axis_tdata  = {3'b000, w_epoch_fraction, w_epoch_seconds};

endmodule

// ----- verif/civil_date_to_epoch_seconds_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// civil_date_to_epoch_seconds_tb
// drives date and time beats through the converter and checks each result
// beat against a fixed-point model of the calendar arithmetic; a table of
// directed timestamps (epoch, leap rules, month carry, rollover, saturation)
// is followed by random dates with random gaps and stalls on both streams
// ============================================================================
module civil_date_to_epoch_seconds_tb;

    localparam longint EPOCH_DAY_COUNT = 1969 * 365 + 1969 / 4 - 1969 / 100 + 1969 / 400;
    localparam longint COUNT_HI        = (64'sd1 <<< 52) - 1;
    localparam longint COUNT_LO        = -COUNT_HI - 1;
    localparam longint SEC_HI          = (64'sd1 <<< 36) - 1;
    localparam int     N_DIRECTED      = 22;
    localparam int     N_RANDOM        = 680;

    typedef struct packed {
        logic signed [cdes_pkg::SEC_W-1:0] seconds;
        logic [cdes_pkg::FRAC_W-1:0]       fraction;
    } t_epoch;

    typedef struct {
        int     year;
        int     month;
        int     day;
        int     hour;
        int     minute;
        int     second;
        int     fraction;
        bit     known;
        longint exp_seconds;
        int     exp_fraction;
    } t_timestamp_row;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // year, month, day, hour, minute, whole_second, second_fraction
    logic [cdes_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // epoch_seconds, epoch_fraction, zero pad
    logic [cdes_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

    t_epoch pending_epochs[$];
    t_epoch oldest_epoch;
    int     fail_count = 0;
    bit     steady_in  = 1'b0;
    bit     steady_out = 1'b0;

    t_timestamp_row directed_rows [N_DIRECTED] = '{
        '{1970,    1,    1,    0,    0,    0,     0, 1'b1,      0,     0},
        '{1969,   12,   31,   23,   59,   59, 32768, 1'b1,     -1, 32768},
        '{9999,   12,   31,   23,   59,   59, 65535, 1'b1, SEC_HI, 65535},
        '{16383, 127,  511,  127,  127,  127, 65535, 1'b1, SEC_HI, 65535},
        '{1,       1,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{0,       1,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{0,    -128, -512, -128, -128, -128,     0, 1'b0,      0,     0},
        '{2000,    3,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{1900,    3,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2004,    2,   29,   12,    0,    0,     0, 1'b0,      0,     0},
        '{2100,    3,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2021,    0,   15,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2021,   13,   15,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2021,  127,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2021,   -1,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2021,    6, -512,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2021,    6,  511,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2021,    6,   15, -128,  127, -128,     0, 1'b0,      0,     0},
        '{2021,    6,   15,  127, -128,  127, 65535, 1'b0,      0,     0},
        '{2177,    1,    1,    0,    0,    0,     0, 1'b0,      0,     0},
        '{2106,    2,    7,    6,   28,   15,     1, 1'b0,      0,     0},
        '{0,       0,    0,    0,    0,    0,     0, 1'b0,      0,     0}
    };

    civil_date_to_epoch_seconds uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [cdes_pkg::IN_DATA_W-1:0] pack_timestamp(
        input logic [13:0] yr,
        input logic [7:0]  mo,
        input logic [9:0]  dy,
        input logic [7:0]  hh,
        input logic [7:0]  mm,
        input logic [7:0]  ss,
        input logic [15:0] fr
    );
        return {fr, ss, mm, hh, dy, mo, yr};
    endfunction

    function automatic t_epoch date_to_epoch(input logic [cdes_pkg::IN_DATA_W-1:0] beat);
        longint yr;
        longint mon;
        longint days;
        longint count;
        t_epoch r;
        yr  = longint'(beat[13:0]);
        mon = longint'($signed(beat[21:14])) - 1;
        yr  = yr + mon / 12;
        mon = mon % 12;
        if (mon < 0) begin
            yr  = yr - 1;
            mon = mon + 12;
        end
        case (mon)
            0:       days = 0;
            1:       days = 31;
            2:       days = 59;
            3:       days = 90;
            4:       days = 120;
            5:       days = 151;
            6:       days = 181;
            7:       days = 212;
            8:       days = 243;
            9:       days = 273;
            10:      days = 304;
            default: days = 334;
        endcase
        if (mon > 1 && yr % 4 == 0 && (yr % 100 != 0 || yr % 400 == 0)) begin
            days = days + 1;
        end
        yr    = yr - 1;
        days  = days + yr * 365 + yr / 4 - yr / 100 + yr / 400;
        count = days + longint'($signed(beat[31:22])) - 1 - EPOCH_DAY_COUNT;
        count = count * 24 + longint'($signed(beat[39:32]));
        count = count * 60 + longint'($signed(beat[47:40]));
        count = count * 60 + longint'($signed(beat[55:48]));
        count = count * 65536 + longint'(beat[71:56]);
        if (count > COUNT_HI) begin
            count = COUNT_HI;
        end
        if (count < COUNT_LO) begin
            count = COUNT_LO;
        end
        r.seconds  = count[52:16];
        r.fraction = count[15:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_timestamp(
        input logic [cdes_pkg::IN_DATA_W-1:0] beat,
        input t_epoch                         expected,
        input bit                             drain
    );
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_epochs.push_back(expected);
        @(negedge i_clk);
        gap = steady_in ? 0 : idle_length();
        if (drain || gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            if (drain) begin
                wait (pending_epochs.size() == 0);
                @(negedge i_clk);
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_epochs.size() == 0) begin
                $error("unexpected result beat %h", m_axis_tdata);
                fail_count++;
            end else begin
                oldest_epoch = pending_epochs.pop_front();
                if (m_axis_tdata[36:0] !== oldest_epoch.seconds) begin
                    $error("epoch_seconds: expected %0d, got %0d",
                           oldest_epoch.seconds, $signed(m_axis_tdata[36:0]));
                    fail_count++;
                end
                if (m_axis_tdata[52:37] !== oldest_epoch.fraction) begin
                    $error("epoch_fraction: expected %0d, got %0d",
                           oldest_epoch.fraction, m_axis_tdata[52:37]);
                    fail_count++;
                end
            end
        end
    end

    // result side backpressure
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady_out && $urandom_range(0, 3) == 0) begin
                    stall = idle_length();
                end
            end
            if ($urandom_range(0, 299) == 0) begin
                steady_out = !steady_out;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[civil_date_to_epoch_seconds] ERROR");
        $finish;
    end

    initial begin
        t_timestamp_row                 row;
        logic [cdes_pkg::IN_DATA_W-1:0] beat;
        t_epoch                         expected;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            row  = directed_rows[n];
            beat = pack_timestamp(14'(row.year), 8'(row.month), 10'(row.day), 8'(row.hour),
                                  8'(row.minute), 8'(row.second), 16'(row.fraction));
            if (row.known) begin
                expected.seconds  = 37'(row.exp_seconds);
                expected.fraction = 16'(row.exp_fraction);
            end else begin
                expected = date_to_epoch(beat);
            end
            send_timestamp(beat, expected, n == N_DIRECTED - 1);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 80 == 0) begin
                steady_in = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 85) begin
                // date and time fields within their usual ranges
                beat = pack_timestamp(
                    14'($urandom_range(0, 9) == 0 ? $urandom_range(1, 9999)
                                                  : $urandom_range(1, 2200)),
                    8'($urandom_range(1, 12)),
                    10'($urandom_range(1, 31)),
                    8'($urandom_range(0, 23)),
                    8'($urandom_range(0, 59)),
                    8'($urandom_range(0, 60)),
                    16'($urandom));
            end else begin
                beat = pack_timestamp(14'($urandom), 8'($urandom), 10'($urandom),
                                      8'($urandom), 8'($urandom), 8'($urandom),
                                      16'($urandom));
            end
            send_timestamp(beat, date_to_epoch(beat), n == N_RANDOM / 2);
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_epochs.size() == 0);
        repeat (cdes_pkg::PIPE_DEPTH * 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[civil_date_to_epoch_seconds] OK");
        end else begin
            $display("[civil_date_to_epoch_seconds] ERROR");
        end
        $finish;
    end

endmodule
